[hdl/aesc_pkg.sv]
// ----------------------------------------------------------------------------
// aesc_pkg: auto exposure step controller package
// Shared widths, reset values, codes and command/status types.
// ----------------------------------------------------------------------------
package aesc_pkg;

  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned EXP_W    = 16;
  localparam int unsigned GAIN_W   = 8;
  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned WSUM_W   = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned EXP_STEP_W  = 13;
  localparam int unsigned GAIN_STEP_W = 7;

  localparam int unsigned SAMPLE_LIMIT_DEF = 64;
  localparam int unsigned GAIN_MIN_DEF     = 0;

  // Luma weights with the channel scaling folded in
  localparam logic [11:0] W_RED   = 12'(8 * 299);
  localparam logic [11:0] W_GREEN = 12'(4 * 587);
  localparam logic [11:0] W_BLUE  = 12'(8 * 114);

  // Divide by 1000 as multiply by ceil(2^28 / 1000), shift by 28
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 999) / 1000);

  localparam logic [LUMA_W-1:0] BRIGHT_DEFAULT = LUMA_W'(128);

  localparam logic [EXP_W-1:0]  EXPOSURE_RST = EXP_W'(1024);
  localparam logic [GAIN_W-1:0] GAIN_RST     = '0;

  localparam logic              AE_ENABLE_RST   = 1'b1;
  localparam logic [7:0]        TARGET_RST      = 8'd128;
  localparam logic [7:0]        THRESHOLD_RST   = 8'd10;
  localparam logic [EXP_W-1:0]  EXP_MIN_RST     = EXP_W'(256);
  localparam logic [EXP_W-1:0]  EXP_MAX_RST     = EXP_W'(4000);
  localparam logic [EXP_STEP_W-1:0]  EXP_STEP_RST  = EXP_STEP_W'(16);
  localparam logic [GAIN_W-1:0]      GAIN_MAX_RST  = GAIN_W'(63);
  localparam logic [GAIN_STEP_W-1:0] GAIN_STEP_RST = GAIN_STEP_W'(1);

  typedef enum logic [1:0] {
    ACT_SAMPLE   = 2'd0,
    ACT_FRAME    = 2'd1,
    ACT_SET_EXP  = 2'd2,
    ACT_SET_GAIN = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AE_ENABLE = 3'd0,
    CFG_TARGET    = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_EXP_MIN   = 3'd3,
    CFG_EXP_MAX   = 3'd4,
    CFG_EXP_STEP  = 3'd5,
    CFG_GAIN_MAX  = 3'd6,
    CFG_GAIN_STEP = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic set_exp;
    logic manual_gain;
    logic luma_mul;
    logic luma_acc;
    logic div_start;
    logic div_take;
    logic bright_default;
    logic adjust;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sample_full;
    logic count_zero;
    logic div_done;
  } status_t;

endpackage

[hdl/aesc_in_if.sv]
// ----------------------------------------------------------------------------
// aesc_in_if: input channel
// Valid/ready channel carrying one action word.
// ----------------------------------------------------------------------------
interface aesc_in_if;
  import aesc_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [PIXEL_W-1:0] pixel;
  logic [15:0]        set_value;

  modport source (output valid, action, pixel, set_value, input ready);
  modport sink   (input valid, action, pixel, set_value, output ready);
endinterface

[hdl/aesc_out_if.sv]
// ----------------------------------------------------------------------------
// aesc_out_if: output channel
// Valid/ready channel carrying one sensor update word.
// ----------------------------------------------------------------------------
interface aesc_out_if;
  import aesc_pkg::*;

  logic              valid;
  logic              ready;
  logic [EXP_W-1:0]  exposure_out;
  logic [GAIN_W-1:0] gain_out;
  logic [LUMA_W-1:0] brightness;
  logic              changed;

  modport source (output valid, exposure_out, gain_out, brightness, changed, input ready);
  modport sink   (input valid, exposure_out, gain_out, brightness, changed, output ready);
endinterface

[hdl/aesc_div.sv]
// ----------------------------------------------------------------------------
// aesc_div: luma sum divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aesc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [aesc_pkg::SUM_W-1:0]  dividend_i,
  input  logic [aesc_pkg::CNT_W-1:0]  divisor_i,
  output logic [aesc_pkg::SUM_W-1:0]  quotient_o,
  output logic                        done_o
);
  import aesc_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[SUM_W-2:0], fits};
      rem_d  = fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[hdl/aesc_dp.sv]
// ----------------------------------------------------------------------------
// aesc_dp: auto exposure datapath
// Settings, luma accumulation, averaging, exposure/gain stepping and output word.
// ----------------------------------------------------------------------------
module aesc_dp #(
  parameter int unsigned SAMPLE_LIMIT = aesc_pkg::SAMPLE_LIMIT_DEF,
  parameter int unsigned GAIN_MIN     = aesc_pkg::GAIN_MIN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aesc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aesc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [aesc_pkg::PIXEL_W-1:0]    pixel_i,
  input  logic [15:0]                     set_value_i,
  input  aesc_pkg::cmd_t                  cmd_i,
  output aesc_pkg::status_t               status_o,
  output logic [aesc_pkg::EXP_W-1:0]      exposure_out_o,
  output logic [aesc_pkg::GAIN_W-1:0]     gain_out_o,
  output logic [aesc_pkg::LUMA_W-1:0]     brightness_o,
  output logic                            changed_o
);
  import aesc_pkg::*;

  localparam int unsigned PROD_W = WSUM_W + RECIP_W;

  // settings
  logic                   ae_enable_q;
  logic [7:0]             target_q;
  logic [7:0]             threshold_q;
  logic [EXP_W-1:0]       exp_min_q;
  logic [EXP_W-1:0]       exp_max_q;
  logic [EXP_STEP_W-1:0]  exp_step_q;
  logic [GAIN_W-1:0]      gain_max_q;
  logic [GAIN_STEP_W-1:0] gain_step_q;

  // state
  logic [EXP_W-1:0]  exposure_q, exposure_d;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  count_q;

  // payload
  logic [WSUM_W-1:0] wsum_q;
  logic [LUMA_W-1:0] luma_q;
  logic [LUMA_W-1:0] bright_q;
  logic              changed_q, changed_d;
  logic [EXP_W-1:0]  out_exp_q;
  logic [GAIN_W-1:0] out_gain_q;
  logic [LUMA_W-1:0] out_bright_q;
  logic              out_changed_q;

  logic [WSUM_W-1:0] wsum;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quotient;
  logic              div_done;

  logic              up;
  logic [7:0]        err;
  logic [EXP_W:0]    exp_sum;
  logic [EXP_W-1:0]  exp_inc, exp_dec;
  logic [GAIN_W:0]   gain_sum;
  logic [GAIN_W-1:0] gain_inc, gain_dec;
  logic              stepped;

  assign wsum = WSUM_W'(pixel_i[15:11]) * WSUM_W'(W_RED)
              + WSUM_W'(pixel_i[10:5])  * WSUM_W'(W_GREEN)
              + WSUM_W'(pixel_i[4:0])   * WSUM_W'(W_BLUE);

  assign prod = PROD_W'(wsum_q) * PROD_W'(RECIP_1000);

  aesc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign up       = target_q > bright_q;
  assign err      = up ? target_q - bright_q : bright_q - target_q;
  assign exp_sum  = {1'b0, exposure_q} + (EXP_W + 1)'(exp_step_q);
  assign exp_inc  = exp_sum[EXP_W] ? '1 : exp_sum[EXP_W-1:0];
  assign exp_dec  = (exposure_q > EXP_W'(exp_step_q)) ? exposure_q - EXP_W'(exp_step_q) : '0;
  assign gain_sum = {1'b0, gain_q} + (GAIN_W + 1)'(gain_step_q);
  assign gain_inc = gain_sum[GAIN_W] ? '1 : gain_sum[GAIN_W-1:0];
  assign gain_dec = (gain_q > GAIN_W'(gain_step_q)) ? gain_q - GAIN_W'(gain_step_q) : '0;

  always_comb begin
    exposure_d = exposure_q;
    gain_d     = gain_q;
    stepped    = 1'b0;
    if (err > threshold_q) begin
      if (up) begin
        if (exposure_q < exp_max_q) begin
          exposure_d = exp_inc;
          stepped    = 1'b1;
        end else if (gain_q < gain_max_q) begin
          gain_d  = gain_inc;
          stepped = 1'b1;
        end
      end else begin
        if (exposure_q > exp_min_q) begin
          exposure_d = exp_dec;
          stepped    = 1'b1;
        end else if (gain_q > GAIN_W'(GAIN_MIN)) begin
          gain_d  = gain_dec;
          stepped = 1'b1;
        end
      end
    end
    changed_d = ae_enable_q & stepped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ae_enable_q <= AE_ENABLE_RST;
      target_q    <= TARGET_RST;
      threshold_q <= THRESHOLD_RST;
      exp_min_q   <= EXP_MIN_RST;
      exp_max_q   <= EXP_MAX_RST;
      exp_step_q  <= EXP_STEP_RST;
      gain_max_q  <= GAIN_MAX_RST;
      gain_step_q <= GAIN_STEP_RST;
      exposure_q  <= EXPOSURE_RST;
      gain_q      <= GAIN_RST;
      sum_q       <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_AE_ENABLE: ae_enable_q <= cfg_data_i[0];
          CFG_TARGET:    target_q    <= cfg_data_i[7:0];
          CFG_THRESHOLD: threshold_q <= cfg_data_i[7:0];
          CFG_EXP_MIN:   exp_min_q   <= cfg_data_i;
          CFG_EXP_MAX:   exp_max_q   <= cfg_data_i;
          CFG_EXP_STEP:  exp_step_q  <= cfg_data_i[EXP_STEP_W-1:0];
          CFG_GAIN_MAX:  gain_max_q  <= cfg_data_i[GAIN_W-1:0];
          CFG_GAIN_STEP: gain_step_q <= cfg_data_i[GAIN_STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.set_exp) begin
        exposure_q <= set_value_i;
      end
      if (cmd_i.manual_gain) begin
        gain_q <= set_value_i[GAIN_W-1:0];
      end
      if (cmd_i.luma_acc) begin
        sum_q   <= sum_q + SUM_W'(luma_q);
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.adjust) begin
        sum_q   <= '0;
        count_q <= '0;
        if (ae_enable_q) begin
          exposure_q <= exposure_d;
          gain_q     <= gain_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wsum_q <= wsum;
    end
    if (cmd_i.luma_mul) begin
      luma_q <= prod[RECIP_SHIFT +: LUMA_W];
    end
    if (cmd_i.set_exp || cmd_i.manual_gain) begin
      bright_q  <= '0;
      changed_q <= 1'b1;
    end
    if (cmd_i.bright_default) begin
      bright_q <= BRIGHT_DEFAULT;
    end
    if (cmd_i.div_take) begin
      bright_q <= quotient[LUMA_W-1:0];
    end
    if (cmd_i.adjust) begin
      changed_q <= changed_d;
    end
    if (cmd_i.load_out) begin
      out_exp_q     <= exposure_q;
      out_gain_q    <= gain_q;
      out_bright_q  <= bright_q;
      out_changed_q <= changed_q;
    end
  end

  assign status_o.sample_full = count_q >= CNT_W'(SAMPLE_LIMIT);
  assign status_o.count_zero  = count_q == '0;
  assign status_o.div_done    = div_done;

  assign exposure_out_o = out_exp_q;
  assign gain_out_o     = out_gain_q;
  assign brightness_o   = out_bright_q;
  assign changed_o      = out_changed_q;

endmodule

[hdl/aesc_ctrl.sv]
// ----------------------------------------------------------------------------
// aesc_ctrl: auto exposure controller
// Sequences each word through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module aesc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_action_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  aesc_pkg::status_t   status_i,
  output aesc_pkg::cmd_t      cmd_o
);
  import aesc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA_MUL,
    ST_LUMA_ACC,
    ST_DIV,
    ST_ADJUST,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    in_ready_o  = state_q == ST_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (action_e'(in_action_i))
            ACT_SAMPLE: begin
              if (!status_i.sample_full) begin
                state_d = ST_LUMA_MUL;
              end
            end
            ACT_FRAME: begin
              if (status_i.count_zero) begin
                cmd_o.bright_default = 1'b1;
                state_d              = ST_ADJUST;
              end else begin
                cmd_o.div_start = 1'b1;
                state_d         = ST_DIV;
              end
            end
            ACT_SET_EXP: begin
              cmd_o.set_exp = 1'b1;
              state_d       = ST_EMIT;
            end
            ACT_SET_GAIN: begin
              cmd_o.manual_gain = 1'b1;
              state_d           = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_LUMA_MUL: begin
        cmd_o.luma_mul = 1'b1;
        state_d        = ST_LUMA_ACC;
      end
      ST_LUMA_ACC: begin
        cmd_o.luma_acc = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = ST_ADJUST;
        end
      end
      ST_ADJUST: begin
        cmd_o.adjust = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/auto_exposure_step_controller_top.sv]
// ----------------------------------------------------------------------------
// auto_exposure_step_controller_top: auto exposure step controller
// Mean-luma auto exposure with exposure-first, gain-second stepping.
// ----------------------------------------------------------------------------
// One word is taken at a time. A sample word passes through accept, luma
// multiply by the reciprocal of 1000 and accumulate, or is only accepted once
// the frame holds SAMPLE_LIMIT samples. An end-of-frame word waits on the
// 14-step restoring divider that forms the average when samples were taken, and
// takes the default brightness otherwise. A word that gives a result waits
// in its last cycle only while the output register still holds an untaken result.
module auto_exposure_step_controller_top #(
  parameter int unsigned SAMPLE_LIMIT = aesc_pkg::SAMPLE_LIMIT_DEF,
  parameter int unsigned GAIN_MIN     = aesc_pkg::GAIN_MIN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aesc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aesc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  aesc_in_if.sink                         in_i,
  aesc_out_if.source                      out_o
);
  import aesc_pkg::*;

  cmd_t    cmd;
  status_t status;

  aesc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  aesc_dp #(
    .SAMPLE_LIMIT (SAMPLE_LIMIT),
    .GAIN_MIN     (GAIN_MIN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_i        (in_i.pixel),
    .set_value_i    (in_i.set_value),
    .cmd_i          (cmd),
    .status_o       (status),
    .exposure_out_o (out_o.exposure_out),
    .gain_out_o     (out_o.gain_out),
    .brightness_o   (out_o.brightness),
    .changed_o      (out_o.changed)
  );

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.set_exp, cmd.manual_gain, cmd.luma_mul, cmd.luma_acc,
              cmd.div_start, cmd.adjust, cmd.load_out}))
    else $error("datapath commands overlap");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !in_i.ready)
    else $error("input taken while averaging");

  a_div_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> !in_i.ready)
    else $error("divider finished outside averaging");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_o.valid)
    else $error("loaded word not presented");

endmodule
